### rtl/graph_traversal_engine_macros.svh
// Assertion macros for the graph traversal engine.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef GRAPH_TRAVERSAL_ENGINE_MACROS_SVH
`define GRAPH_TRAVERSAL_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GTE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GTE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/gte_pkg.sv
// Shared types and codes of the graph traversal engine.
// No dependencies; imported by the result buffer and the top level.
package gte_pkg;

	localparam logic       KIND_EDGE   = 1'b0;
	localparam logic       KIND_START  = 1'b1;
	localparam logic [1:0] MODE_DFS    = 2'd0;
	localparam logic [1:0] MODE_BFS    = 2'd1;
	localparam logic [1:0] MODE_CYCLE  = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;
	localparam int         MAX_RESULTS = 32;

	typedef enum logic [3:0] {
		S_IDLE,
		S_E_RD,
		S_E_WR,
		S_E_LNK,
		S_R_SCAN,
		S_D_EDGE,
		S_D_POP,
		S_D_TGT,
		S_D_HEAD,
		S_B_DEQ,
		S_B_DQW,
		S_B_HEAD,
		S_B_EDGE,
		S_B_TGT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [4:0] vertex;
		logic       cycle_found;
		logic       empty_graph;
		logic       edge_dropped;
		logic       last;
	} res_t;

	typedef struct packed {
		logic push;
		logic fin;
		res_t data;
	} buf_ctrl_t;

	typedef struct packed {
		logic can_push;
		logic fin_ok;
		logic pend_vld;
	} buf_stat_t;

endpackage

### rtl/gte_if.sv
// Handshake channels of the graph traversal engine: input items and results.
// No dependencies.
interface gte_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [4:0] from_vertex;
	logic [4:0] to_vertex;
	logic       both_ways;

	modport source (output valid, kind, from_vertex, to_vertex, both_ways, input ready);
	modport sink (input valid, kind, from_vertex, to_vertex, both_ways, output ready);
endinterface

interface gte_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] vertex;
	logic       cycle_found;
	logic       empty_graph;
	logic       edge_dropped;
	logic       last;

	modport source (output valid, vertex, cycle_found, empty_graph, edge_dropped, last,
		input ready);
	modport sink (input valid, vertex, cycle_found, empty_graph, edge_dropped, last,
		output ready);
endinterface

### rtl/gte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gte_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/gte_result_buf.sv
// Result buffer: one pending result plus the output register.
// The pending slot lets the final result of an item be marked last.
// Depends on gte_pkg and gte_result_if.
module gte_result_buf
	import gte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  buf_ctrl_t ctrl,
	output buf_stat_t stat,
	gte_result_if.source result
);

	logic pend_vld_q;
	logic out_vld_q;
	res_t pend_q;
	res_t out_q;
	logic out_free;

	assign out_free      = !out_vld_q || result.ready;
	assign stat.can_push = !pend_vld_q || out_free;
	assign stat.fin_ok   = pend_vld_q && out_free;
	assign stat.pend_vld = pend_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (ctrl.push && stat.can_push) begin
			pend_vld_q <= 1'b1;
			if (pend_vld_q) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end else if (ctrl.fin && stat.fin_ok) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && stat.can_push) begin
			pend_q <= ctrl.data;
			if (pend_vld_q) begin
				out_q <= {pend_q.vertex, pend_q.cycle_found, pend_q.empty_graph,
					pend_q.edge_dropped, 1'b0};
			end
		end else if (ctrl.fin && stat.fin_ok) begin
			out_q <= {pend_q.vertex, pend_q.cycle_found, pend_q.empty_graph,
				pend_q.edge_dropped, 1'b1};
		end
	end

	assign result.valid        = out_vld_q;
	assign result.vertex       = out_q.vertex;
	assign result.cycle_found  = out_q.cycle_found;
	assign result.empty_graph  = out_q.empty_graph;
	assign result.edge_dropped = out_q.edge_dropped;
	assign result.last         = out_q.last;

endmodule

### rtl/graph_traversal_engine.sv
// Graph traversal engine: adjacency-list store with depth-first and
// breadth-first walks and an undirected cycle check.
// Depends on gte_pkg, gte_if, gte_ram, gte_result_buf and the macro header.
//
// Usage: items arrive on the item channel. An edge item (kind 0) appends
// to_vertex to the list of from_vertex, and the reverse edge too when
// both_ways is set; it gives one result whose edge_dropped flag tells
// whether some half did not fit. A start item (kind 1) runs the walk that
// walk_mode selects: the walks give one result per visited vertex (at most
// 32), the cycle check one result with cycle_found. The final result of each
// item carries last. walk_mode is written through cfg_we and cfg_wdata.
// Flow: one item at a time; item.ready is high only while idle. An edge
// item reads, writes and links each stored half in turn, then hands over
// its result. A walk scans the roots and visits vertices in depth-first or
// breadth-first order, following each stored edge, since each step waits on
// one registered read of the list, stack and queue memories. A result leaves
// through a pending slot and an output register; when the receiver stalls
// the walk holds at its next visit. Reset clears the store (present and
// head-valid bits, edge count) at once; no clearing pass is needed.
`include "graph_traversal_engine_macros.svh"

module graph_traversal_engine
	import gte_pkg::*;
#(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	gte_item_if.sink     item,
	gte_result_if.source result
);

	localparam int VIW = $clog2(MAX_VERTICES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int EIW = $clog2(MAX_EDGES);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int FW  = 2 * VIW + ECW;
	localparam int NOW = $clog2(MAX_RESULTS + 1);
	localparam logic [ECW-1:0] END_MARK = ECW'(MAX_EDGES);

	state_t state_q, state_d;
	logic [1:0] walk_mode_q;

	logic [MAX_VERTICES-1:0] present_q, present_d;
	logic [MAX_VERTICES-1:0] visited_q, visited_d;
	logic [MAX_VERTICES-1:0] head_vld_q, head_vld_d;
	logic [ECW-1:0] ecnt_q, ecnt_d;
	logic [VCW-1:0] r_q, r_d;
	logic [VCW-1:0] sp_q, sp_d;
	logic [VCW-1:0] qh_q, qh_d;
	logic [VCW-1:0] qn_q, qn_d;
	logic [NOW-1:0] nout_q, nout_d;
	logic pass_q, pass_d;
	logic drop_q, drop_d;
	logic lnk_q, lnk_d;

	logic [VIW-1:0] cu_q, cu_d, cv_q, cv_d;
	logic both_q, both_d;
	logic [EIW-1:0] tlast_q, tlast_d, eold_q, eold_d;
	logic [VIW-1:0] tv_q, tv_d, tp_q, tp_d;
	logic [ECW-1:0] te_q, te_d;

	logic           head_we, tail_we, tgt_we, nxt_we, stk_we, que_we;
	logic [VIW-1:0] head_waddr, head_raddr, tail_waddr, que_waddr;
	logic [ECW-1:0] head_wdata, head_rdata, nxt_wdata, nxt_rdata;
	logic [EIW-1:0] tail_wdata, tail_rdata, tgt_waddr, nxt_waddr;
	logic [VIW-1:0] tgt_wdata, tgt_rdata, que_wdata, que_rdata;
	logic [VIW-1:0] stk_waddr, stk_raddr;
	logic [FW-1:0]  stk_wdata, stk_rdata;

	buf_ctrl_t bctl;
	buf_stat_t bst;

	logic [VIW+4:0] from_x, to_x, t_x, r_x;
	logic           ids_ok, emit_ok, stall;
	logic [VIW-1:0] rv, t;
	logic [VCW-1:0] sp_m1, sp_m2;
	logic [ECW-1:0] head_te;

	assign from_x  = {{VIW{1'b0}}, item.from_vertex};
	assign to_x    = {{VIW{1'b0}}, item.to_vertex};
	assign ids_ok  = (from_x < (VIW + 5)'(MAX_VERTICES)) && (to_x < (VIW + 5)'(MAX_VERTICES));
	assign rv      = r_q[VIW-1:0];
	assign t       = tgt_rdata;
	assign t_x     = {5'd0, t};
	assign r_x     = {5'd0, rv};
	assign sp_m1   = sp_q - VCW'(1);
	assign sp_m2   = sp_q - VCW'(2);
	assign head_te = head_vld_q[tv_q] ? head_rdata : END_MARK;
	assign emit_ok = ((walk_mode_q == MODE_DFS) || (walk_mode_q == MODE_BFS)) &&
		(nout_q < NOW'(MAX_RESULTS));
	assign stall   = emit_ok && !bst.can_push;

	assign item.ready = (state_q == S_IDLE);

	// Read addresses follow the registers that the sequencer holds, so a
	// held state re-reads the same entries.
	assign tail_waddr = cu_q;
	assign stk_raddr  = sp_m2[VIW-1:0];
	assign stk_waddr  = sp_m1[VIW-1:0];
	assign stk_wdata  = {tv_q, nxt_rdata, tp_q};

	always_comb begin
		unique case (state_q)
			S_R_SCAN: head_raddr = rv;
			S_D_TGT:  head_raddr = t;
			S_B_DQW:  head_raddr = que_rdata;
			default:  head_raddr = cu_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_mode_q <= MODE_DFS;
		end else if (cfg_we) begin
			walk_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			present_q  <= '0;
			visited_q  <= '0;
			head_vld_q <= '0;
			ecnt_q     <= '0;
			r_q        <= '0;
			sp_q       <= '0;
			qh_q       <= '0;
			qn_q       <= '0;
			nout_q     <= '0;
			pass_q     <= 1'b0;
			drop_q     <= 1'b0;
			lnk_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			present_q  <= present_d;
			visited_q  <= visited_d;
			head_vld_q <= head_vld_d;
			ecnt_q     <= ecnt_d;
			r_q        <= r_d;
			sp_q       <= sp_d;
			qh_q       <= qh_d;
			qn_q       <= qn_d;
			nout_q     <= nout_d;
			pass_q     <= pass_d;
			drop_q     <= drop_d;
			lnk_q      <= lnk_d;
		end
	end

	always_ff @(posedge clk) begin
		cu_q    <= cu_d;
		cv_q    <= cv_d;
		both_q  <= both_d;
		tlast_q <= tlast_d;
		eold_q  <= eold_d;
		tv_q    <= tv_d;
		tp_q    <= tp_d;
		te_q    <= te_d;
	end

	always_comb begin
		state_d    = state_q;
		present_d  = present_q;
		visited_d  = visited_q;
		head_vld_d = head_vld_q;
		ecnt_d     = ecnt_q;
		r_d        = r_q;
		sp_d       = sp_q;
		qh_d       = qh_q;
		qn_d       = qn_q;
		nout_d     = nout_q;
		pass_d     = pass_q;
		drop_d     = drop_q;
		lnk_d      = lnk_q;
		cu_d       = cu_q;
		cv_d       = cv_q;
		both_d     = both_q;
		tlast_d    = tlast_q;
		eold_d     = eold_q;
		tv_d       = tv_q;
		tp_d       = tp_q;
		te_d       = te_q;

		head_we    = 1'b0;
		head_waddr = cu_q;
		head_wdata = ecnt_q;
		tail_we    = 1'b0;
		tail_wdata = ecnt_q[EIW-1:0];
		tgt_we     = 1'b0;
		tgt_waddr  = ecnt_q[EIW-1:0];
		tgt_wdata  = cv_q;
		nxt_we     = 1'b0;
		nxt_waddr  = ecnt_q[EIW-1:0];
		nxt_wdata  = END_MARK;
		stk_we     = 1'b0;
		que_we     = 1'b0;
		que_waddr  = qn_q[VIW-1:0];
		que_wdata  = t;

		bctl       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					if (item.kind == KIND_EDGE) begin
						if (!ids_ok) begin
							bctl.push              = 1'b1;
							bctl.data.edge_dropped = 1'b1;
							state_d                = S_FLUSH;
						end else begin
							present_d[from_x[VIW-1:0]] = 1'b1;
							present_d[to_x[VIW-1:0]]   = 1'b1;
							cu_d    = from_x[VIW-1:0];
							cv_d    = to_x[VIW-1:0];
							both_d  = item.both_ways;
							pass_d  = 1'b0;
							drop_d  = 1'b0;
							state_d = S_E_RD;
						end
					end else begin
						visited_d = '0;
						nout_d    = '0;
						if (walk_mode_q == MODE_NONE) begin
							bctl.push = 1'b1;
							state_d   = S_FLUSH;
						end else if (present_q == '0) begin
							bctl.push             = 1'b1;
							bctl.data.empty_graph = 1'b1;
							state_d               = S_FLUSH;
						end else begin
							r_d     = '0;
							state_d = S_R_SCAN;
						end
					end
				end
			end

			S_E_RD: begin
				state_d = S_E_WR;
			end

			S_E_WR: begin
				if (ecnt_q < END_MARK) begin
					tgt_we  = 1'b1;
					nxt_we  = 1'b1;
					tail_we = 1'b1;
					if (!head_vld_q[cu_q]) begin
						head_we          = 1'b1;
						head_vld_d[cu_q] = 1'b1;
						lnk_d            = 1'b0;
					end else begin
						lnk_d = 1'b1;
					end
					tlast_d = tail_rdata;
					eold_d  = ecnt_q[EIW-1:0];
					ecnt_d  = ecnt_q + ECW'(1);
				end else begin
					drop_d = 1'b1;
					lnk_d  = 1'b0;
				end
				state_d = S_E_LNK;
			end

			S_E_LNK: begin
				nxt_waddr = tlast_q;
				nxt_wdata = ECW'(eold_q);
				nxt_we    = lnk_q;
				if (both_q && !pass_q) begin
					cu_d    = cv_q;
					cv_d    = cu_q;
					pass_d  = 1'b1;
					state_d = S_E_RD;
				end else begin
					bctl.push              = 1'b1;
					bctl.data.edge_dropped = drop_q;
					state_d                = S_FLUSH;
				end
			end

			S_R_SCAN: begin
				if (r_q == VCW'(MAX_VERTICES)) begin
					if (walk_mode_q == MODE_CYCLE) begin
						bctl.push = 1'b1;
					end
					state_d = S_FLUSH;
				end else if (present_q[rv] && !visited_q[rv]) begin
					if (!stall) begin
						visited_d[rv]    = 1'b1;
						bctl.push        = emit_ok;
						bctl.data.vertex = r_x[4:0];
						if (emit_ok) begin
							nout_d = nout_q + NOW'(1);
						end
						if (walk_mode_q == MODE_BFS) begin
							que_we    = 1'b1;
							que_waddr = '0;
							que_wdata = rv;
							qh_d      = '0;
							qn_d      = VCW'(1);
							state_d   = S_B_DEQ;
						end else begin
							tv_d    = rv;
							sp_d    = VCW'(1);
							state_d = S_D_HEAD;
						end
					end
				end else begin
					r_d = r_q + VCW'(1);
				end
			end

			S_D_HEAD: begin
				te_d    = head_te;
				state_d = S_D_EDGE;
			end

			S_D_EDGE: begin
				if (te_q == END_MARK) begin
					if (sp_q == VCW'(1)) begin
						r_d     = r_q + VCW'(1);
						state_d = S_R_SCAN;
					end else begin
						sp_d    = sp_m1;
						state_d = S_D_POP;
					end
				end else begin
					state_d = S_D_TGT;
				end
			end

			S_D_POP: begin
				tv_d    = stk_rdata[FW-1 -: VIW];
				te_d    = stk_rdata[VIW+ECW-1 -: ECW];
				tp_d    = stk_rdata[VIW-1:0];
				state_d = S_D_EDGE;
			end

			S_D_TGT: begin
				if (!visited_q[t]) begin
					if (!stall) begin
						visited_d[t]     = 1'b1;
						bctl.push        = emit_ok;
						bctl.data.vertex = t_x[4:0];
						if (emit_ok) begin
							nout_d = nout_q + NOW'(1);
						end
						// The current frame goes to the stack with its edge already
						// advanced; the new vertex becomes the register-held top.
						stk_we  = 1'b1;
						tp_d    = tv_q;
						tv_d    = t;
						sp_d    = sp_q + VCW'(1);
						state_d = S_D_HEAD;
					end
				end else if ((walk_mode_q == MODE_CYCLE) &&
						((sp_q < VCW'(2)) || (t != tp_q))) begin
					bctl.push             = 1'b1;
					bctl.data.cycle_found = 1'b1;
					state_d               = S_FLUSH;
				end else begin
					te_d    = nxt_rdata;
					state_d = S_D_EDGE;
				end
			end

			S_B_DEQ: begin
				if (qh_q == qn_q) begin
					r_d     = r_q + VCW'(1);
					state_d = S_R_SCAN;
				end else begin
					qh_d    = qh_q + VCW'(1);
					state_d = S_B_DQW;
				end
			end

			S_B_DQW: begin
				tv_d    = que_rdata;
				state_d = S_B_HEAD;
			end

			S_B_HEAD: begin
				te_d    = head_te;
				state_d = S_B_EDGE;
			end

			S_B_EDGE: begin
				state_d = (te_q == END_MARK) ? S_B_DEQ : S_B_TGT;
			end

			S_B_TGT: begin
				if (!visited_q[t]) begin
					if (!stall) begin
						visited_d[t]     = 1'b1;
						bctl.push        = emit_ok;
						bctl.data.vertex = t_x[4:0];
						if (emit_ok) begin
							nout_d = nout_q + NOW'(1);
						end
						que_we  = 1'b1;
						qn_d    = qn_q + VCW'(1);
						te_d    = nxt_rdata;
						state_d = S_B_EDGE;
					end
				end else begin
					te_d    = nxt_rdata;
					state_d = S_B_EDGE;
				end
			end

			S_FLUSH: begin
				bctl.fin = 1'b1;
				if (bst.fin_ok) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	gte_ram #(.W(ECW), .D(MAX_VERTICES)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	gte_ram #(.W(EIW), .D(MAX_VERTICES)) u_tail_ram (
		.clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
		.raddr(cu_q), .rdata(tail_rdata)
	);

	gte_ram #(.W(VIW), .D(MAX_EDGES)) u_tgt_ram (
		.clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
		.raddr(te_q[EIW-1:0]), .rdata(tgt_rdata)
	);

	gte_ram #(.W(ECW), .D(MAX_EDGES)) u_nxt_ram (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(te_q[EIW-1:0]), .rdata(nxt_rdata)
	);

	gte_ram #(.W(FW), .D(MAX_VERTICES)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	gte_ram #(.W(VIW), .D(MAX_VERTICES)) u_que_ram (
		.clk(clk), .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
		.raddr(qh_q[VIW-1:0]), .rdata(que_rdata)
	);

	gte_result_buf u_result_buf (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(bctl),
		.stat(bst),
		.result(result)
	);

	`GTE_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= VCW'(MAX_VERTICES), "stack depth overflow")
	`GTE_ASSERT_IMP(a_ecnt_bound, 1'b1, ecnt_q <= END_MARK, "edge count overflow")
	`GTE_ASSERT_IMP(a_queue_order, state_q == S_B_DEQ, qh_q <= qn_q, "queue head passed tail")
	`GTE_ASSERT_IMP(a_idle_empty, item.valid && item.ready, !bst.pend_vld,
		"item accepted while a result is pending")
	`GTE_ASSERT_NXT(a_flush_last, (state_q == S_FLUSH) && bst.fin_ok,
		result.valid && result.last, "final result not marked last")

endmodule
